FILE: src/lsk_pkg.sv
// ----------------------------------------------------------------------------
// lsk_pkg
// Shared widths, types and helpers of the two-tap line skew block.
// ----------------------------------------------------------------------------
package lsk_pkg;

  localparam int MaxLine = 4096;

  localparam int PixW  = 16;
  localparam int OffW  = 14;
  localparam int WgtW  = 16;
  localparam int DstW  = 13;
  localparam int RunW  = 13;
  localparam int FracW = WgtW;

  localparam int SiW   = $clog2(MaxLine + 1);
  localparam int PosW  = ((SiW > OffW) ? SiW : OffW) + 2;
  localparam int WpW   = DstW + 1;
  localparam int TrlW  = WpW + 1;
  localparam int ProdW = PixW + WgtW + 1;
  localparam int SumW  = ProdW + 2;

  localparam int SlotCount = 4;
  localparam int QDepth    = 4;
  localparam int QAw       = $clog2(QDepth);

  localparam logic [DstW-1:0] DstReset = DstW'(4096);

  localparam int SlotLead  = 0;
  localparam int SlotPixel = 1;
  localparam int SlotShare = 2;
  localparam int SlotTail  = 3;

  typedef enum logic {
    KindPixel = 1'b0,
    KindRun   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [WgtW-1:0] weight;
    logic            first;
    logic            last;
    logic            lead_v;
    logic [RunW-1:0] lead_len;
    logic            pix_v;
    logic            share_v;
    logic            share_eol;
    logic            tail_v;
    logic [RunW-1:0] tail_len;
  } stage_t;

  typedef struct packed {
    kind_e           kind;
    logic [PixW-1:0] value;
    logic [RunW-1:0] run_length;
    logic            eol;
  } result_t;

  typedef struct packed {
    logic [SlotCount-1:0] mask;
    result_t [SlotCount-1:0] res;
  } bundle_t;

  // signed divide by 2^FracW, truncated toward zero
  function automatic logic [PixW-1:0] trunc_frac(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] adj;
    adj = x + (x[SumW-1] ? SumW'((1 << FracW) - 1) : SumW'(0));
    return adj[FracW+PixW-1:FracW];
  endfunction

endpackage

FILE: src/lsk_ctrl.sv
// ----------------------------------------------------------------------------
// lsk_ctrl
// Input transfer, line position tracking and the registered input stage.
// ----------------------------------------------------------------------------
module lsk_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [lsk_pkg::PixW-1:0] pixel_i,
  input  logic signed [lsk_pkg::OffW-1:0] skew_offset_i,
  input  logic [lsk_pkg::WgtW-1:0]    blend_weight_i,
  input  logic                        first_of_line_i,
  input  logic                        last_of_line_i,
  input  logic [lsk_pkg::DstW-1:0]    dest_length_i,
  input  logic                        advance_i,
  output logic                        stage_valid_o,
  output lsk_pkg::stage_t             stage_o
);

  logic                            accept;
  logic                            stage_valid_q, stage_valid_d;
  lsk_pkg::stage_t                 stage_q, stage_d;
  logic signed [lsk_pkg::OffW-1:0] offset_q, offset;
  logic [lsk_pkg::WgtW-1:0]        weight_q, weight;
  logic [lsk_pkg::SiW-1:0]         si_q, si, si_n;
  logic [lsk_pkg::WpW-1:0]         wp_q, wp0, wp1, wp2, wp3;
  logic signed [lsk_pkg::PosW-1:0] off_x, dst_x, gmin, si_x, sin_x, pos, end_pos;
  logic signed [lsk_pkg::TrlW-1:0] trail;
  logic                            lead_v, in_lim, pix_v, lo, trail_pos;
  logic [lsk_pkg::RunW-1:0]        lead_len;

  assign in_stall_o    = stage_valid_q && !advance_i;
  assign accept        = in_valid_i && !in_stall_o;
  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

  always_comb begin
    offset   = first_of_line_i ? skew_offset_i : offset_q;
    weight   = first_of_line_i ? blend_weight_i : weight_q;
    si       = first_of_line_i ? '0 : si_q;
    wp0      = first_of_line_i ? '0 : wp_q;
    off_x    = lsk_pkg::PosW'(offset);
    dst_x    = $signed({{(lsk_pkg::PosW-lsk_pkg::DstW){1'b0}}, dest_length_i});
    gmin     = (off_x < dst_x) ? off_x : dst_x;
    lead_v   = first_of_line_i && (off_x > 0) && (gmin > 0);
    lead_len = lsk_pkg::RunW'(gmin);
    wp1      = wp0 + (lead_v ? lsk_pkg::WpW'(lead_len) : '0);
    si_x     = $signed({{(lsk_pkg::PosW-lsk_pkg::SiW){1'b0}}, si});
    pos      = si_x + off_x;
    in_lim   = si < lsk_pkg::SiW'(lsk_pkg::MaxLine);
    pix_v    = in_lim && (pos >= 0) && (pos < dst_x);
    wp2      = wp1 + lsk_pkg::WpW'(pix_v);
    si_n     = si + lsk_pkg::SiW'(in_lim);
    sin_x    = $signed({{(lsk_pkg::PosW-lsk_pkg::SiW){1'b0}}, si_n});
    end_pos  = sin_x + off_x;
    lo       = (end_pos >= 0) && (end_pos < dst_x);
    wp3      = wp2 + lsk_pkg::WpW'(lo);
    trail    = $signed({2'b00, dest_length_i}) - $signed({1'b0, wp3});
    trail_pos = trail > 0;

    stage_d.pixel     = pixel_i;
    stage_d.weight    = weight;
    stage_d.first     = first_of_line_i;
    stage_d.last      = last_of_line_i;
    stage_d.lead_v    = lead_v;
    stage_d.lead_len  = lead_len;
    stage_d.pix_v     = pix_v;
    stage_d.share_v   = last_of_line_i && lo;
    stage_d.share_eol = !trail_pos;
    stage_d.tail_v    = last_of_line_i && (trail_pos || !lo);
    stage_d.tail_len  = trail_pos ? lsk_pkg::RunW'(trail) : '0;

    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (advance_i) begin
      stage_valid_d = 1'b0;
    end else begin
      stage_valid_d = stage_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      offset_q      <= '0;
      weight_q      <= '0;
      si_q          <= '0;
      wp_q          <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (accept) begin
        offset_q <= offset;
        weight_q <= weight;
        if (last_of_line_i) begin
          si_q <= '0;
          wp_q <= '0;
        end else begin
          si_q <= si_n;
          wp_q <= wp2;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

endmodule

FILE: src/lsk_blend.sv
// ----------------------------------------------------------------------------
// lsk_blend
// Two-tap blend of the staged pixel and assembly of its result bundle.
// ----------------------------------------------------------------------------
module lsk_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  lsk_pkg::stage_t   stage_i,
  output lsk_pkg::bundle_t  bundle_o
);

  logic signed [lsk_pkg::ProdW-1:0] prod, left_q, left_use;
  logic signed [lsk_pkg::SumW-1:0]  sum;
  logic [lsk_pkg::PixW-1:0]         blended, share;

  assign prod = lsk_pkg::ProdW'($signed(stage_i.pixel)) *
                lsk_pkg::ProdW'($signed({1'b0, stage_i.weight}));
  assign left_use = stage_i.first ? '0 : left_q;
  assign sum = (lsk_pkg::SumW'($signed(stage_i.pixel)) <<< lsk_pkg::FracW)
             - lsk_pkg::SumW'(prod) + lsk_pkg::SumW'(left_use);
  assign blended = lsk_pkg::trunc_frac(sum);
  assign share   = lsk_pkg::trunc_frac(lsk_pkg::SumW'(prod));

  always_comb begin
    bundle_o.mask = '0;
    bundle_o.mask[lsk_pkg::SlotLead]  = stage_i.lead_v;
    bundle_o.mask[lsk_pkg::SlotPixel] = stage_i.pix_v;
    bundle_o.mask[lsk_pkg::SlotShare] = stage_i.share_v;
    bundle_o.mask[lsk_pkg::SlotTail]  = stage_i.tail_v;

    bundle_o.res[lsk_pkg::SlotLead].kind       = lsk_pkg::KindRun;
    bundle_o.res[lsk_pkg::SlotLead].value      = '0;
    bundle_o.res[lsk_pkg::SlotLead].run_length = stage_i.lead_len;
    bundle_o.res[lsk_pkg::SlotLead].eol        = 1'b0;

    bundle_o.res[lsk_pkg::SlotPixel].kind       = lsk_pkg::KindPixel;
    bundle_o.res[lsk_pkg::SlotPixel].value      = blended;
    bundle_o.res[lsk_pkg::SlotPixel].run_length = '0;
    bundle_o.res[lsk_pkg::SlotPixel].eol        = 1'b0;

    bundle_o.res[lsk_pkg::SlotShare].kind       = lsk_pkg::KindPixel;
    bundle_o.res[lsk_pkg::SlotShare].value      = share;
    bundle_o.res[lsk_pkg::SlotShare].run_length = '0;
    bundle_o.res[lsk_pkg::SlotShare].eol        = stage_i.share_eol;

    bundle_o.res[lsk_pkg::SlotTail].kind       = lsk_pkg::KindRun;
    bundle_o.res[lsk_pkg::SlotTail].value      = '0;
    bundle_o.res[lsk_pkg::SlotTail].run_length = stage_i.tail_len;
    bundle_o.res[lsk_pkg::SlotTail].eol        = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (advance_i) begin
      left_q <= stage_i.last ? '0 : prod;
    end
  end

endmodule

FILE: src/lsk_queue.sv
// ----------------------------------------------------------------------------
// lsk_queue
// Bundle queue; hands out the valid results of each bundle one per transfer.
// ----------------------------------------------------------------------------
module lsk_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  lsk_pkg::bundle_t         bundle_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lsk_pkg::result_t         result_o
);

  lsk_pkg::bundle_t                  entries_q [lsk_pkg::QDepth];
  lsk_pkg::bundle_t                  head;
  logic [lsk_pkg::QAw-1:0]           wr_q, rd_q;
  logic [lsk_pkg::QAw:0]             count_q, count_d;
  logic [lsk_pkg::SlotCount-1:0]     done_q, pend, sel;
  logic [$clog2(lsk_pkg::SlotCount)-1:0] sel_idx;
  logic                              pop_res, pop_entry;

  assign head        = entries_q[rd_q];
  assign pend        = head.mask & ~done_q;
  assign full_o      = count_q == (lsk_pkg::QAw+1)'(lsk_pkg::QDepth);
  assign out_valid_o = count_q != '0;
  assign pop_res     = out_valid_o && !out_stall_i;
  assign pop_entry   = pop_res && ((pend & ~sel) == '0);
  assign result_o    = head.res[sel_idx];

  always_comb begin
    sel     = '0;
    sel_idx = '0;
    for (int i = lsk_pkg::SlotCount - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel     = '0;
        sel[i]  = 1'b1;
        sel_idx = i[$clog2(lsk_pkg::SlotCount)-1:0];
      end
    end
    count_d = count_q + (lsk_pkg::QAw+1)'(push_i) - (lsk_pkg::QAw+1)'(pop_entry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      done_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_entry) begin
        rd_q   <= rd_q + 1'b1;
        done_q <= '0;
      end else if (pop_res) begin
        done_q <= done_q | sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= bundle_i;
    end
  end

endmodule

FILE: src/line_skew_two_tap.sv
// ----------------------------------------------------------------------------
// line_skew_two_tap
// Two-tap line skew for three-shear rotation: blend, clip and gap runs.
// ----------------------------------------------------------------------------
// The first result of a pixel can transfer once it has passed the input stage
// register and its bundle is in the queue. One pixel per cycle while the queue
// has room; each result takes one transfer; a four-bundle queue absorbs bursts.
// Reset clears line state, leftover and the queue; dest_length returns to 4096.
// ----------------------------------------------------------------------------
module line_skew_two_tap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lsk_pkg::DstW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [lsk_pkg::PixW-1:0] pixel_i,
  input  logic signed [lsk_pkg::OffW-1:0] skew_offset_i,
  input  logic [lsk_pkg::WgtW-1:0]    blend_weight_i,
  input  logic                        first_of_line_i,
  input  logic                        last_of_line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic signed [lsk_pkg::PixW-1:0] value_o,
  output logic [lsk_pkg::RunW-1:0]    run_length_o,
  output logic                        end_of_line_o
);

  logic [lsk_pkg::DstW-1:0] dest_length_q;
  logic                     stage_valid, full, advance;
  lsk_pkg::stage_t          stage;
  lsk_pkg::bundle_t         bundle;
  lsk_pkg::result_t         result;

  assign cfg_ready_o = 1'b1;
  assign advance     = stage_valid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_length_q <= lsk_pkg::DstReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dest_length_q <= cfg_data_i;
    end
  end

  lsk_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .skew_offset_i   (skew_offset_i),
    .blend_weight_i  (blend_weight_i),
    .first_of_line_i (first_of_line_i),
    .last_of_line_i  (last_of_line_i),
    .dest_length_i   (dest_length_q),
    .advance_i       (advance),
    .stage_valid_o   (stage_valid),
    .stage_o         (stage)
  );

  lsk_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .stage_i   (stage),
    .bundle_o  (bundle)
  );

  lsk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && (bundle.mask != '0)),
    .bundle_i    (bundle),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign kind_o        = result.kind;
  assign value_o       = result.value;
  assign run_length_o  = result.run_length;
  assign end_of_line_o = result.eol;

endmodule
